// File: rtl/csi_amplitude_liveness_detector_core_defines.svh
// Assertion macros used by the checker file.
`ifndef CSI_AMPLITUDE_LIVENESS_DETECTOR_CORE_DEFINES_SVH
`define CSI_AMPLITUDE_LIVENESS_DETECTOR_CORE_DEFINES_SVH

// Same-cycle implication under reset.
`define CSIALD_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication under reset.
`define CSIALD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/csiald_pkg.sv
`default_nettype none
package csiald_pkg;

  localparam int unsigned WINDOW_SAMPLES_DEF = 1024;
  localparam int unsigned HEADER_BYTES_DEF   = 20;
  localparam int unsigned QUEUE_DEPTH        = 4;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam int unsigned POS_W = 18;
  localparam logic [POS_W-1:0] POS_MAX = 18'h3FFFF;
  localparam logic [POS_W-1:0] MAGIC_LEN    = 18'd4;
  localparam logic [POS_W-1:0] COUNT_LO_POS = 18'd6;
  localparam logic [POS_W-1:0] COUNT_HI_POS = 18'd7;

  localparam int unsigned DIV_NUM_W = 32;
  localparam int unsigned DIV_DEN_W = 16;
  localparam int unsigned PAIR_ROOT_STEPS = 16;

  localparam logic [15:0] LINGER_MS_RST     = 16'd5000;
  localparam logic [7:0]  CHECK_PERIOD_RST  = 8'd100;
  localparam logic [7:0]  CALIB_SECS_RST    = 8'd30;
  localparam logic [15:0] INIT_THRESH_RST   = 16'd1280;
  localparam logic [15:0] THRESH_FLOOR_RST  = 16'd512;
  localparam logic [3:0]  THRESH_GAIN_RST   = 4'd3;
  localparam logic [10:0] MIN_SAMPLES_RST   = 11'd100;

  localparam logic [7:0] EMPTY_SECS_MAX  = 8'd255;
  localparam logic [7:0] EMPTY_SECS_STEP = 8'd2;

  typedef enum logic [1:0] {
    OP_FRAME_BYTE  = 2'd0,
    OP_ROOM_REPORT = 2'd1,
    OP_TICK        = 2'd2,
    OP_CALIBRATE   = 2'd3
  } opcode_e;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_LINGER_MS     = 3'd0,
    CFG_CHECK_PERIOD  = 3'd1,
    CFG_CALIB_SECS    = 3'd2,
    CFG_INIT_THRESH   = 3'd3,
    CFG_THRESH_FLOOR  = 3'd4,
    CFG_THRESH_GAIN   = 3'd5,
    CFG_MIN_SAMPLES   = 3'd6
  } cfg_index_e;

  typedef enum logic [3:0] {
    B_IDLE,
    B_PAIR,
    B_FEND,
    B_DIV_SAMPLE,
    B_RMS_START,
    B_SWEEP,
    B_SQUARE,
    B_ROOT_GO,
    B_ROOT_WAIT,
    B_DIV_RMS,
    B_APPLY,
    B_EMIT
  } back_state_e;

  // One classified item handed from the parser to the executor.
  typedef struct packed {
    opcode_e     op;
    logic        empty_still;
    logic        pair_valid;
    logic [7:0]  inphase;
    logic [7:0]  quad;
    logic        frame_end;
    logic        frame_good;
    logic [15:0] count;
  } cmd_t;

  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = 8'hC5;
      2'd1:    b = 8'h11;
      2'd2:    b = 8'h00;
      default: b = 8'h01;
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

// File: rtl/csiald_front.sv
`default_nettype none
module csiald_front #(
  parameter int unsigned HEADER_BYTES = csiald_pkg::HEADER_BYTES_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output      logic              in_stall_o,
  input  wire logic [1:0]        opcode_i,
  input  wire logic [7:0]        data_byte_i,
  input  wire logic              last_byte_i,
  input  wire logic              empty_still_i,
  input  wire logic              full_i,
  output      logic              push_o,
  output csiald_pkg::cmd_t       cmd_o
);

  localparam int unsigned PW = csiald_pkg::POS_W;
  localparam logic [PW-1:0] HDR = PW'(HEADER_BYTES);

  logic [PW-1:0] pos_q, pos_d;
  logic [15:0]   cnt_q, cnt_d;
  logic [7:0]    held_q, held_d;
  logic          bad_q, bad_d;

  logic [PW-1:0] k;
  logic [15:0]   cnt_n;
  logic [7:0]    held_n;
  logic          bad_n;
  logic          pair;
  logic [PW:0]   len;
  logic [PW:0]   need;
  logic          is_frame;

  assign in_stall_o = full_i;
  assign push_o     = in_valid_i && !full_i;
  assign is_frame   = (csiald_pkg::opcode_e'(opcode_i) == csiald_pkg::OP_FRAME_BYTE);

  always_comb begin
    pos_d  = pos_q;
    cnt_d  = cnt_q;
    held_d = held_q;
    bad_d  = bad_q;

    bad_n = bad_q;
    if (pos_q < csiald_pkg::MAGIC_LEN &&
        data_byte_i != csiald_pkg::magic_byte(pos_q[1:0])) begin
      bad_n = 1'b1;
    end
    cnt_n = cnt_q;
    if (pos_q == csiald_pkg::COUNT_LO_POS) cnt_n[7:0] = data_byte_i;
    if (pos_q == csiald_pkg::COUNT_HI_POS) cnt_n[15:8] = data_byte_i;

    // Even payload offsets hold I, odd ones complete a pair within the count.
    k      = pos_q - HDR;
    held_n = held_q;
    pair   = 1'b0;
    if (pos_q >= HDR) begin
      if (!k[0]) held_n = data_byte_i;
      else if (k[PW-1:1] < {1'b0, cnt_n}) pair = 1'b1;
    end

    len  = {1'b0, pos_q} + {{PW{1'b0}}, 1'b1};
    need = (PW+1)'(HEADER_BYTES) + {2'b00, cnt_n, 1'b0};

    cmd_o             = '0;
    cmd_o.op          = csiald_pkg::opcode_e'(opcode_i);
    cmd_o.empty_still = empty_still_i;
    cmd_o.inphase     = held_q;
    cmd_o.quad        = data_byte_i;
    cmd_o.count       = cnt_n;
    if (is_frame) begin
      cmd_o.pair_valid = pair;
      cmd_o.frame_end  = last_byte_i;
      cmd_o.frame_good = (len >= (PW+1)'(HEADER_BYTES)) && !bad_n &&
                         (cnt_n != 16'd0) && (len >= need);
    end

    if (push_o && is_frame) begin
      if (last_byte_i) begin
        pos_d  = '0;
        cnt_d  = '0;
        held_d = '0;
        bad_d  = 1'b0;
      end else begin
        pos_d  = (pos_q < csiald_pkg::POS_MAX) ? pos_q + 1'b1 : pos_q;
        cnt_d  = cnt_n;
        held_d = held_n;
        bad_d  = bad_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      cnt_q  <= '0;
      held_q <= '0;
      bad_q  <= 1'b0;
    end else begin
      pos_q  <= pos_d;
      cnt_q  <= cnt_d;
      held_q <= held_d;
      bad_q  <= bad_d;
    end
  end

endmodule
`default_nettype wire

// File: rtl/csiald_queue.sv
`default_nettype none
module csiald_queue #(
  parameter int unsigned DEPTH = csiald_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  csiald_pkg::cmd_t      data_i,
  output      logic             full_o,
  output      logic             valid_o,
  input  wire logic             pop_i,
  output csiald_pkg::cmd_t      data_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  csiald_pkg::cmd_t mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      if (do_pop)  rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      if (do_push && !do_pop)      cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule
`default_nettype wire

// File: rtl/csiald_isqrt.sv
`default_nettype none
// Digit-by-digit integer square root, one root bit per cycle.
module csiald_isqrt #(
  parameter int unsigned X_W = 54
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start_i,
  input  wire logic [X_W-1:0]                 x_i,
  input  wire logic [$clog2(X_W/2+1)-1:0]     steps_i,
  output      logic                           done_o,
  output      logic [X_W/2-1:0]               root_o
);

  localparam int unsigned R_W = X_W / 2;
  localparam int unsigned S_W = $clog2(R_W + 1);

  logic           busy_q, done_q;
  logic [S_W-1:0] cnt_q;
  logic [X_W-1:0] x_q;
  logic [R_W+1:0] rem_q;
  logic [R_W-1:0] root_q;

  logic [R_W+1:0] rem_sh, trial;
  logic           ge;

  assign rem_sh = {rem_q[R_W-1:0], x_q[X_W-1:X_W-2]};
  assign trial  = {root_q, 2'b01};
  assign ge     = (rem_sh >= trial);
  assign done_o = done_q;
  assign root_o = root_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= steps_i;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == S_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= x_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      x_q    <= {x_q[X_W-3:0], 2'b00};
      rem_q  <= ge ? rem_sh - trial : rem_sh;
      root_q <= {root_q[R_W-2:0], ge};
    end
  end

endmodule
`default_nettype wire

// File: rtl/csiald_div.sv
`default_nettype none
// Restoring divider, one quotient bit per cycle.
module csiald_div (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start_i,
  input  wire logic [csiald_pkg::DIV_NUM_W-1:0] num_i,
  input  wire logic [csiald_pkg::DIV_DEN_W-1:0] den_i,
  output      logic                             done_o,
  output      logic [csiald_pkg::DIV_NUM_W-1:0] quo_o
);

  localparam int unsigned N_W = csiald_pkg::DIV_NUM_W;
  localparam int unsigned D_W = csiald_pkg::DIV_DEN_W;
  localparam int unsigned C_W = $clog2(N_W + 1);

  logic           busy_q, done_q;
  logic [C_W-1:0] cnt_q;
  logic [N_W-1:0] quo_q;
  logic [D_W-1:0] den_q;
  logic [D_W-1:0] rem_q;
  logic [D_W:0]   rsh;
  logic           ge;

  assign rsh    = {rem_q, quo_q[N_W-1]};
  assign ge     = (rsh >= {1'b0, den_q});
  assign done_o = done_q;
  assign quo_o  = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= C_W'(N_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == C_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? D_W'(rsh - {1'b0, den_q}) : rsh[D_W-1:0];
      quo_q <= {quo_q[N_W-2:0], ge};
    end
  end

endmodule
`default_nettype wire

// File: rtl/csiald_back.sv
`default_nettype none
module csiald_back #(
  parameter int unsigned WINDOW_SAMPLES = csiald_pkg::WINDOW_SAMPLES_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cmd_valid_i,
  input  csiald_pkg::cmd_t                        cmd_i,
  output      logic                               pop_o,
  input  wire logic                               cfg_valid_i,
  output      logic                               cfg_ready_o,
  input  wire logic [csiald_pkg::CFG_INDEX_W-1:0] cfg_index_i,
  input  wire logic [csiald_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output      logic                               out_valid_o,
  input  wire logic                               out_stall_i,
  output      logic                               live_o,
  output      logic [15:0]                        rms_o,
  output      logic [15:0]                        threshold_o,
  output      logic                               frame_accepted_o,
  output      logic                               check_done_o,
  output      logic                               calibrated_o
);

  localparam int unsigned AW  = $clog2(WINDOW_SAMPLES);
  localparam int unsigned CW  = $clog2(WINDOW_SAMPLES + 1);
  localparam int unsigned SW  = 16 + CW;
  localparam int unsigned DW  = 32 + 2 * CW;
  localparam int unsigned RW  = DW / 2;
  localparam int unsigned MW  = (CW > 11) ? CW : 11;
  localparam int unsigned STW = $clog2(RW + 1);

  csiald_pkg::back_state_e state_q, state_d;
  csiald_pkg::cmd_t        cmd_q, cmd_d;

  // configuration
  logic [15:0] linger_q, linger_d;
  logic [7:0]  period_q, period_d;
  logic [7:0]  calsecs_q, calsecs_d;
  logic [15:0] init_thr_q, init_thr_d;
  logic [15:0] floor_q, floor_d;
  logic [3:0]  gain_q, gain_d;
  logic [10:0] min_q, min_d;

  // detector state
  logic [31:0]   sum_q, sum_d;
  logic [AW-1:0] wp_q, wp_d;
  logic [CW-1:0] total_q, total_d;
  logic          live_q, live_d;
  logic [31:0]   la_q, la_d;
  logic [31:0]   now_q, now_d;
  logic [15:0]   thr_q, thr_d;
  logic [7:0]    es_q, es_d;
  logic [7:0]    fc_q, fc_d;
  logic [15:0]   rms_q, rms_d;
  logic          acc_q, acc_d, chk_q, chk_d, cal_q, cal_d;

  // window sweep
  logic [CW-1:0] idx_q, idx_d;
  logic          v1_q, v1_d, v2_q, v2_d;
  logic [15:0]   rdata_q;
  logic [31:0]   sq_q, sq_d;
  logic [SW-1:0] s_q, s_d;
  logic [DW-1:0] nq_q, nq_d, ss_q, ss_d;
  logic [15:0]   rmsv_q, rmsv_d;

  // result register
  logic        out_valid_q, out_valid_d;
  logic        o_live_q, o_live_d;
  logic [15:0] o_rms_q, o_rms_d, o_thr_q, o_thr_d;
  logic        o_acc_q, o_acc_d, o_chk_q, o_chk_d, o_cal_q, o_cal_d;

  logic [15:0] mem_q [WINDOW_SAMPLES];
  logic        mem_we, rd_en;
  logic [15:0] wdata;

  logic           sqrt_start, sqrt_done;
  logic [DW-1:0]  sqrt_x;
  logic [STW-1:0] sqrt_steps;
  logic [RW-1:0]  sqrt_root;
  logic           div_start, div_done;
  logic [csiald_pkg::DIV_NUM_W-1:0] div_num, div_quo;
  logic [csiald_pkg::DIV_DEN_W-1:0] div_den;

  logic signed [15:0] isq, qsq;
  logic [15:0] mag;
  logic [7:0]  fc_inc;
  logic        hit, live_n, do_cal;
  logic [31:0] la_n;
  logic [19:0] cal_t, cal_f;

  assign cfg_ready_o      = 1'b1;
  assign out_valid_o      = out_valid_q;
  assign live_o           = o_live_q;
  assign rms_o            = o_rms_q;
  assign threshold_o      = o_thr_q;
  assign frame_accepted_o = o_acc_q;
  assign check_done_o     = o_chk_q;
  assign calibrated_o     = o_cal_q;

  assign isq = $signed(cmd_i.inphase) * $signed(cmd_i.inphase);
  assign qsq = $signed(cmd_i.quad) * $signed(cmd_i.quad);
  assign mag = 16'(isq) + 16'(qsq);

  csiald_isqrt #(.X_W(DW)) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .x_i     (sqrt_x),
    .steps_i (sqrt_steps),
    .done_o  (sqrt_done),
    .root_o  (sqrt_root)
  );

  csiald_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  always_comb begin
    state_d = state_q;
    cmd_d   = cmd_q;
    linger_d = linger_q; period_d = period_q; calsecs_d = calsecs_q;
    init_thr_d = init_thr_q; floor_d = floor_q; gain_d = gain_q; min_d = min_q;
    sum_d = sum_q; wp_d = wp_q; total_d = total_q; live_d = live_q; la_d = la_q;
    now_d = now_q; thr_d = thr_q; es_d = es_q; fc_d = fc_q; rms_d = rms_q;
    acc_d = acc_q; chk_d = chk_q; cal_d = cal_q;
    idx_d = idx_q; v1_d = 1'b0; v2_d = 1'b0; sq_d = sq_q; s_d = s_q;
    nq_d = nq_q; ss_d = ss_q; rmsv_d = rmsv_q;
    out_valid_d = out_valid_q && out_stall_i;
    o_live_d = o_live_q; o_rms_d = o_rms_q; o_thr_d = o_thr_q;
    o_acc_d = o_acc_q; o_chk_d = o_chk_q; o_cal_d = o_cal_q;
    pop_o = 1'b0;
    mem_we = 1'b0;
    wdata = div_quo[15:0];
    rd_en = 1'b0;
    sqrt_start = 1'b0;
    sqrt_x     = {mag, 16'h0000, {(DW-32){1'b0}}};
    sqrt_steps = STW'(csiald_pkg::PAIR_ROOT_STEPS);
    div_start  = 1'b0;
    div_num    = sum_q;
    div_den    = cmd_q.count;
    fc_inc = fc_q + 8'd1;
    hit    = (rmsv_q > thr_q);
    la_n   = hit ? now_q : la_q;
    live_n = live_q || hit;
    if (live_n && (now_q - la_n) > {16'h0000, linger_q}) live_n = 1'b0;
    do_cal = 1'b0;
    cal_t  = 20'(rmsv_q) * 20'(gain_q);
    cal_f  = (cal_t < {4'h0, floor_q}) ? {4'h0, floor_q} : cal_t;

    unique case (state_q)
      csiald_pkg::B_IDLE: begin
        if (cmd_valid_i) begin
          pop_o = 1'b1;
          cmd_d = cmd_i;
          acc_d = 1'b0;
          chk_d = 1'b0;
          cal_d = 1'b0;
          unique case (cmd_i.op)
            csiald_pkg::OP_FRAME_BYTE: begin
              if (cmd_i.pair_valid) begin
                sqrt_start = 1'b1;
                state_d    = csiald_pkg::B_PAIR;
              end else begin
                state_d = csiald_pkg::B_FEND;
              end
            end
            csiald_pkg::OP_ROOM_REPORT: begin
              if (!cmd_i.empty_still) es_d = '0;
              else if (es_q > csiald_pkg::EMPTY_SECS_MAX - csiald_pkg::EMPTY_SECS_STEP)
                es_d = csiald_pkg::EMPTY_SECS_MAX;
              else es_d = es_q + csiald_pkg::EMPTY_SECS_STEP;
              state_d = csiald_pkg::B_EMIT;
            end
            csiald_pkg::OP_TICK: begin
              now_d   = now_q + 32'd1;
              state_d = csiald_pkg::B_EMIT;
            end
            csiald_pkg::OP_CALIBRATE: begin
              cal_d   = 1'b1;
              state_d = csiald_pkg::B_RMS_START;
            end
            default: state_d = csiald_pkg::B_EMIT;
          endcase
        end
      end
      csiald_pkg::B_PAIR: begin
        if (sqrt_done) begin
          sum_d   = sum_q + 32'(sqrt_root[15:0]);
          state_d = csiald_pkg::B_FEND;
        end
      end
      csiald_pkg::B_FEND: begin
        if (!cmd_q.frame_end) begin
          state_d = csiald_pkg::B_EMIT;
        end else if (!cmd_q.frame_good) begin
          sum_d   = '0;
          state_d = csiald_pkg::B_EMIT;
        end else begin
          div_start = 1'b1;
          state_d   = csiald_pkg::B_DIV_SAMPLE;
        end
      end
      csiald_pkg::B_DIV_SAMPLE: begin
        if (div_done) begin
          mem_we = 1'b1;
          wp_d   = (wp_q == AW'(WINDOW_SAMPLES - 1)) ? '0 : wp_q + 1'b1;
          if (total_q < CW'(WINDOW_SAMPLES)) total_d = total_q + 1'b1;
          sum_d = '0;
          acc_d = 1'b1;
          if (fc_inc >= period_q) begin
            fc_d    = '0;
            chk_d   = 1'b1;
            state_d = csiald_pkg::B_RMS_START;
          end else begin
            fc_d    = fc_inc;
            state_d = csiald_pkg::B_EMIT;
          end
        end
      end
      csiald_pkg::B_RMS_START: begin
        if (MW'(total_q) < MW'(min_q) || total_q == '0) begin
          rmsv_d  = '0;
          state_d = csiald_pkg::B_APPLY;
        end else begin
          idx_d   = '0;
          s_d     = '0;
          nq_d    = '0;
          state_d = csiald_pkg::B_SWEEP;
        end
      end
      csiald_pkg::B_SWEEP: begin
        // Read one entry per cycle; square next; scale by n and accumulate last.
        rd_en = (idx_q < total_q);
        if (rd_en) idx_d = idx_q + 1'b1;
        v1_d = rd_en;
        v2_d = v1_q;
        if (v1_q) begin
          s_d  = s_q + SW'(rdata_q);
          sq_d = 32'(rdata_q) * 32'(rdata_q);
        end
        if (v2_q) nq_d = nq_q + DW'(total_q * sq_q);
        if (!rd_en && !v1_q && !v2_q) state_d = csiald_pkg::B_SQUARE;
      end
      csiald_pkg::B_SQUARE: begin
        ss_d    = DW'(s_q * s_q);
        state_d = csiald_pkg::B_ROOT_GO;
      end
      csiald_pkg::B_ROOT_GO: begin
        sqrt_start = 1'b1;
        sqrt_x     = nq_q - ss_q;
        sqrt_steps = STW'(RW);
        state_d    = csiald_pkg::B_ROOT_WAIT;
      end
      csiald_pkg::B_ROOT_WAIT: begin
        if (sqrt_done) begin
          div_start = 1'b1;
          div_num   = csiald_pkg::DIV_NUM_W'(sqrt_root);
          div_den   = csiald_pkg::DIV_DEN_W'(total_q);
          state_d   = csiald_pkg::B_DIV_RMS;
        end
      end
      csiald_pkg::B_DIV_RMS: begin
        if (div_done) begin
          rmsv_d  = div_quo[15:0];
          state_d = csiald_pkg::B_APPLY;
        end
      end
      csiald_pkg::B_APPLY: begin
        if (cmd_q.op == csiald_pkg::OP_CALIBRATE) begin
          do_cal = 1'b1;
        end else begin
          rms_d  = rmsv_q;
          live_d = live_n;
          la_d   = la_n;
          do_cal = (es_q >= calsecs_q);
          cal_d  = do_cal;
        end
        if (do_cal) begin
          rms_d = rmsv_q;
          thr_d = (cal_f > 20'h0FFFF) ? 16'hFFFF : cal_f[15:0];
          es_d  = '0;
        end
        state_d = csiald_pkg::B_EMIT;
      end
      csiald_pkg::B_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          o_live_d    = live_q;
          o_rms_d     = rms_q;
          o_thr_d     = thr_q;
          o_acc_d     = acc_q;
          o_chk_d     = chk_q;
          o_cal_d     = cal_q;
          state_d     = csiald_pkg::B_IDLE;
        end
      end
      default: state_d = csiald_pkg::B_IDLE;
    endcase

    if (cfg_valid_i) begin
      unique case (csiald_pkg::cfg_index_e'(cfg_index_i))
        csiald_pkg::CFG_LINGER_MS:    linger_d  = cfg_data_i;
        csiald_pkg::CFG_CHECK_PERIOD: period_d  = cfg_data_i[7:0];
        csiald_pkg::CFG_CALIB_SECS:   calsecs_d = cfg_data_i[7:0];
        csiald_pkg::CFG_INIT_THRESH: begin
          init_thr_d = cfg_data_i;
          thr_d      = cfg_data_i;
        end
        csiald_pkg::CFG_THRESH_FLOOR: floor_d = cfg_data_i;
        csiald_pkg::CFG_THRESH_GAIN:  gain_d  = cfg_data_i[3:0];
        csiald_pkg::CFG_MIN_SAMPLES:  min_d   = cfg_data_i[10:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[wp_q] <= wdata;
    if (rd_en)  rdata_q <= mem_q[idx_q[AW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    sq_q   <= sq_d;
    s_q    <= s_d;
    nq_q   <= nq_d;
    ss_q   <= ss_d;
    rmsv_q <= rmsv_d;
    idx_q  <= idx_d;
    o_live_q <= o_live_d;
    o_rms_q  <= o_rms_d;
    o_thr_q  <= o_thr_d;
    o_acc_q  <= o_acc_d;
    o_chk_q  <= o_chk_d;
    o_cal_q  <= o_cal_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= csiald_pkg::B_IDLE;
      linger_q   <= csiald_pkg::LINGER_MS_RST;
      period_q   <= csiald_pkg::CHECK_PERIOD_RST;
      calsecs_q  <= csiald_pkg::CALIB_SECS_RST;
      init_thr_q <= csiald_pkg::INIT_THRESH_RST;
      floor_q    <= csiald_pkg::THRESH_FLOOR_RST;
      gain_q     <= csiald_pkg::THRESH_GAIN_RST;
      min_q      <= csiald_pkg::MIN_SAMPLES_RST;
      sum_q      <= '0;
      wp_q       <= '0;
      total_q    <= '0;
      live_q     <= 1'b0;
      la_q       <= '0;
      now_q      <= '0;
      thr_q      <= csiald_pkg::INIT_THRESH_RST;
      es_q       <= '0;
      fc_q       <= '0;
      rms_q      <= '0;
      acc_q      <= 1'b0;
      chk_q      <= 1'b0;
      cal_q      <= 1'b0;
      v1_q       <= 1'b0;
      v2_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      linger_q   <= linger_d;
      period_q   <= period_d;
      calsecs_q  <= calsecs_d;
      init_thr_q <= init_thr_d;
      floor_q    <= floor_d;
      gain_q     <= gain_d;
      min_q      <= min_d;
      sum_q      <= sum_d;
      wp_q       <= wp_d;
      total_q    <= total_d;
      live_q     <= live_d;
      la_q       <= la_d;
      now_q      <= now_d;
      thr_q      <= thr_d;
      es_q       <= es_d;
      fc_q       <= fc_d;
      rms_q      <= rms_d;
      acc_q      <= acc_d;
      chk_q      <= chk_d;
      cal_q      <= cal_d;
      v1_q       <= v1_d;
      v2_q       <= v2_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule
`default_nettype wire

// File: rtl/csi_amplitude_liveness_detector_core.sv
`default_nettype none
// Channel   Handshake               Payload
// input     in_valid_i / in_stall_o  opcode_i, data_byte_i, last_byte_i, empty_still_i
// result    out_valid_o / out_stall_i live_o, rms_o, threshold_o, frame_accepted_o,
//                                     check_done_o, calibrated_o
// config    cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// Each transaction in gives exactly one result transaction, in order.
// Plain frame bytes, room reports and ticks go straight to the result; a byte that
// completes an I/Q pair adds a bit-serial root; the last byte of a good frame
// adds a bit-serial divide. A liveness check or calibration sweeps the
// window through its single read port, then runs a bit-serial root and divide.
// Reset is asynchronous and active low; the window store is not cleared, since
// only entries already written are ever read.
// A 4-entry command queue lets the parser keep taking transactions while the
// executor works or the result register waits on out_stall_i.
module csi_amplitude_liveness_detector_core #(
  parameter int unsigned WINDOW_SAMPLES = csiald_pkg::WINDOW_SAMPLES_DEF,
  parameter int unsigned HEADER_BYTES   = csiald_pkg::HEADER_BYTES_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output      logic                               in_stall_o,
  input  wire logic [1:0]                         opcode_i,
  input  wire logic [7:0]                         data_byte_i,
  input  wire logic                               last_byte_i,
  input  wire logic                               empty_still_i,
  input  wire logic                               cfg_valid_i,
  output      logic                               cfg_ready_o,
  input  wire logic [csiald_pkg::CFG_INDEX_W-1:0] cfg_index_i,
  input  wire logic [csiald_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output      logic                               out_valid_o,
  input  wire logic                               out_stall_i,
  output      logic                               live_o,
  output      logic [15:0]                        rms_o,
  output      logic [15:0]                        threshold_o,
  output      logic                               frame_accepted_o,
  output      logic                               check_done_o,
  output      logic                               calibrated_o
);

  // Parser output into the queue, and queue head into the executor.
  csiald_pkg::cmd_t push_cmd, head_cmd;
  logic             push, full, head_valid, pop;

  // Front: track frame header, magic, count and I/Q pairing per byte.
  csiald_front #(.HEADER_BYTES(HEADER_BYTES)) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .opcode_i      (opcode_i),
    .data_byte_i   (data_byte_i),
    .last_byte_i   (last_byte_i),
    .empty_still_i (empty_still_i),
    .full_i        (full),
    .push_o        (push),
    .cmd_o         (push_cmd)
  );

  // Decouple the two sides.
  csiald_queue #(.DEPTH(csiald_pkg::QUEUE_DEPTH)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_cmd),
    .full_o  (full),
    .valid_o (head_valid),
    .pop_i   (pop),
    .data_o  (head_cmd)
  );

  // Back: amplitudes, window, RMS, liveness, calibration and the result register.
  csiald_back #(.WINDOW_SAMPLES(WINDOW_SAMPLES)) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_valid_i      (head_valid),
    .cmd_i            (head_cmd),
    .pop_o            (pop),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .live_o           (live_o),
    .rms_o            (rms_o),
    .threshold_o      (threshold_o),
    .frame_accepted_o (frame_accepted_o),
    .check_done_o     (check_done_o),
    .calibrated_o     (calibrated_o)
  );

endmodule
`default_nettype wire

// File: rtl/csiald_checker.sv
`default_nettype none
`include "csi_amplitude_liveness_detector_core_defines.svh"
module csiald_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic        live_o,
  input wire logic [15:0] rms_o,
  input wire logic [15:0] threshold_o,
  input wire logic        frame_accepted_o,
  input wire logic        check_done_o,
  input wire logic        calibrated_o
);

  `CSIALD_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o, "result dropped while stalled")
  `CSIALD_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_o && out_stall_i, $stable(rms_o) && $stable(threshold_o) && $stable(live_o), "result changed while stalled")
  `CSIALD_ASSERT_IMPLY(a_check_needs_frame, clk_i, rst_ni, out_valid_o && check_done_o, frame_accepted_o, "check without accepted frame")
  `CSIALD_ASSERT_IMPLY(a_frame_cal_needs_check, clk_i, rst_ni, out_valid_o && frame_accepted_o && calibrated_o, check_done_o, "frame calibration without check")

endmodule

bind csi_amplitude_liveness_detector_core csiald_checker u_csiald_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .live_o           (live_o),
  .rms_o            (rms_o),
  .threshold_o      (threshold_o),
  .frame_accepted_o (frame_accepted_o),
  .check_done_o     (check_done_o),
  .calibrated_o     (calibrated_o)
);
`default_nettype wire
